>>> rtl/core/cagc_pkg.sv
`default_nettype none
package cagc_pkg;

  typedef struct packed {
    logic        en;
    logic        load;
    logic        sh16;
    logic [65:0] init;
    logic [47:0] a;
    logic [16:0] b;
  } mac_ctl_t;

  localparam logic [2:0] REG_BANDWIDTH    = 3'd0;
  localparam logic [2:0] REG_ENERGY_FLOOR = 3'd1;
  localparam logic [2:0] REG_GAIN_CEILING = 3'd2;
  localparam logic [2:0] REG_OUTPUT_SCALE = 3'd3;
  localparam logic [2:0] REG_HOLD_GAIN    = 3'd4;
  localparam logic [2:0] REG_PRESET_GAIN  = 3'd5;

  localparam logic [16:0] ONE_Q16    = 17'd65536;
  localparam logic [47:0] ENERGY_ONE = 48'h0001_0000_0000;
  localparam logic [43:0] GAIN_ONE   = 44'd16777216;
  localparam logic [47:0] MAX48      = 48'hFFFF_FFFF_FFFF;

  function automatic logic signed [15:0] sat16(input logic neg, input logic [47:0] mag);
    logic signed [15:0] r;
    if (neg) begin
      if (mag >= 48'd32768) r = 16'sh8000;
      else r = 16'(-mag[15:0]);
    end else begin
      if (mag > 48'd32767) r = 16'sh7FFF;
      else r = 16'(mag[15:0]);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/complex_sample_agc.sv
`default_nettype none
// channel   direction  handshake            payload
// input     in         in_valid / in_stall   in_i, in_q
// output    out        out_valid / out_stall out_i, out_q, gain_now, gain_before_clamp
// config    in         apb psel / penable    paddr, pwdata, prdata
//
// one request at a time through a shared 48x17 multiply-accumulate unit
// locked: energy is tracked, the gain is held and applied, output scaling is skipped
// unlocked at or below floor: gain kept, clamped to the ceiling, then output scaling
// unlocked above floor: gain updated through a log2 of 16 squarings, an exp and a gain multiply
// synchronous active-high reset loads the register and state reset values
// a finished result waits in the output register while the next request is taken
module complex_sample_agc (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] in_i,
  input  wire logic signed [15:0] in_q,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      out_i,
  output logic signed [15:0]      out_q,
  output logic [43:0]             gain_now,
  output logic [47:0]             gain_before_clamp,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [5:0]         paddr,
  input  wire logic [63:0]        pwdata,
  output logic [63:0]             prdata,
  output logic                    pready
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_YI, ST_YQ, ST_EI0, ST_EI1, ST_EQ0, ST_EQ1, ST_SE0, ST_SE1, ST_SEW,
    ST_NRM, ST_SQ0, ST_SQ1, ST_SQN, ST_LG, ST_EX, ST_T1, ST_T2, ST_T3, ST_GR, ST_GW,
    ST_OU0, ST_OU1, ST_OU2, ST_OU3, ST_OU4, ST_OUL, ST_DONE
  } state_t;

  state_t state;

  logic [16:0] bandwidth;
  logic [32:0] energy_floor;
  logic [43:0] gain_ceiling;
  logic [23:0] output_scale;
  logic        hold_gain;
  logic [43:0] preset_gain;

  logic [43:0] gain;
  logic [47:0] energy;
  logic [47:0] unclamped;

  logic [15:0] xi_mag, xq_mag;
  logic        si, sq;
  logic [35:0] yi_mag, yq_mag;
  logic [47:0] e_val;
  logic [47:0] nrm;
  logic [5:0]  p;
  logic [3:0]  step;
  logic [31:0] m;
  logic [15:0] frac;
  logic        lneg;
  logic [15:0] f;
  logic [5:0]  s;
  logic [61:0] gcalc;
  logic signed [15:0] oi, oq;

  cagc_pkg::mac_ctl_t mac;
  logic [65:0] acc;

  logic        cfg_wr;
  logic [2:0]  cfg_idx;
  logic [16:0] alpha;
  logic [24:0] ci, cq;
  logic [51:0] e4;
  logic [5:0]  sh_amt;
  logic        nz;
  logic [47:0] nrm_next;
  logic [32:0] mq;
  logic signed [6:0]  p_m32;
  logic signed [22:0] lval;
  logic [21:0] lmag;
  logic [21:0] r_ex;
  logic signed [22:0] ex;
  logic [6:0]  s_full;
  logic [47:0] ug_next;
  logic [47:0] se_next;

  cagc_mac u_mac (
    .clk(clk),
    .ctl(mac),
    .acc(acc)
  );

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign cfg_idx  = paddr[5:3];
  assign in_stall = (state != ST_IDLE);

  assign alpha    = (bandwidth > cagc_pkg::ONE_Q16) ? cagc_pkg::ONE_Q16 : bandwidth;
  assign ci       = (yi_mag > 36'h100_0000) ? 25'h100_0000 : yi_mag[24:0];
  assign cq       = (yq_mag > 36'h100_0000) ? 25'h100_0000 : yq_mag[24:0];
  assign e4       = {acc[49:0], 2'b00};
  assign sh_amt   = 6'd32 >> step;
  assign nz       = ((nrm >> (6'd48 - sh_amt)) == 48'd0);
  assign nrm_next = nz ? (nrm << sh_amt) : nrm;
  assign mq       = acc[63:31];
  assign p_m32    = $signed({1'b0, p}) - 7'sd32;
  assign lval     = {p_m32, frac};
  assign lmag     = lval[22] ? 22'(-lval) : lval[21:0];
  assign r_ex     = acc[38:17];
  assign ex       = lneg ? $signed({1'b0, r_ex}) : -$signed({1'b0, r_ex});
  assign s_full   = 7'd16 - 7'(ex[22:16]);
  assign ug_next  = (gcalc > {14'd0, cagc_pkg::MAX48}) ? cagc_pkg::MAX48 : gcalc[47:0];
  assign se_next  = acc[63:16];

  always_comb begin
    unique case (cfg_idx)
      cagc_pkg::REG_BANDWIDTH:    prdata = {47'd0, bandwidth};
      cagc_pkg::REG_ENERGY_FLOOR: prdata = {31'd0, energy_floor};
      cagc_pkg::REG_GAIN_CEILING: prdata = {20'd0, gain_ceiling};
      cagc_pkg::REG_OUTPUT_SCALE: prdata = {40'd0, output_scale};
      cagc_pkg::REG_HOLD_GAIN:    prdata = {63'd0, hold_gain};
      cagc_pkg::REG_PRESET_GAIN:  prdata = {20'd0, preset_gain};
      default:                    prdata = 64'd0;
    endcase
  end

  always_comb begin
    mac      = '0;
    mac.en   = 1'b1;
    mac.load = 1'b1;
    unique case (state)
      ST_YI: begin
        mac.init = 66'h80_0000;
        mac.a    = {4'd0, gain};
        mac.b    = {1'b0, xi_mag};
      end
      ST_YQ: begin
        mac.init = 66'h80_0000;
        mac.a    = {4'd0, gain};
        mac.b    = {1'b0, xq_mag};
      end
      ST_EI0: begin
        mac.a = {23'd0, ci};
        mac.b = {1'b0, ci[15:0]};
      end
      ST_EI1: begin
        mac.load = 1'b0;
        mac.sh16 = 1'b1;
        mac.a    = {23'd0, ci};
        mac.b    = {8'd0, ci[24:16]};
      end
      ST_EQ0: begin
        mac.load = 1'b0;
        mac.a    = {23'd0, cq};
        mac.b    = {1'b0, cq[15:0]};
      end
      ST_EQ1: begin
        mac.load = 1'b0;
        mac.sh16 = 1'b1;
        mac.a    = {23'd0, cq};
        mac.b    = {8'd0, cq[24:16]};
      end
      ST_SE0: begin
        mac.init = 66'h8000;
        mac.a    = energy;
        mac.b    = cagc_pkg::ONE_Q16 - alpha;
      end
      ST_SE1: begin
        mac.load = 1'b0;
        mac.a    = e_val;
        mac.b    = alpha;
      end
      ST_SQ0: begin
        mac.a = {16'd0, m};
        mac.b = {1'b0, m[15:0]};
      end
      ST_SQ1: begin
        mac.load = 1'b0;
        mac.sh16 = 1'b1;
        mac.a    = {16'd0, m};
        mac.b    = {1'b0, m[31:16]};
      end
      ST_LG: begin
        mac.init = 66'h1_0000;
        mac.a    = {26'd0, lmag};
        mac.b    = alpha;
      end
      ST_EX: begin
        mac.a = 48'd5155;
        mac.b = {1'b0, ex[15:0]};
      end
      ST_T1: begin
        mac.a = 48'd14822 + {30'd0, acc[33:16]};
        mac.b = {1'b0, f};
      end
      ST_T2: begin
        mac.a = 48'd45559 + {30'd0, acc[33:16]};
        mac.b = {1'b0, f};
      end
      ST_T3: begin
        mac.init = (s == 6'd0) ? 66'd0 : (66'd1 << (s - 6'd1));
        mac.a    = {4'd0, gain};
        mac.b    = cagc_pkg::ONE_Q16 + 17'(acc[33:16]);
      end
      ST_OU0: begin
        mac.init = 66'h8000;
        mac.a    = {12'd0, yi_mag};
        mac.b    = {1'b0, output_scale[15:0]};
      end
      ST_OU1: begin
        mac.load = 1'b0;
        mac.sh16 = 1'b1;
        mac.a    = {12'd0, yi_mag};
        mac.b    = {9'd0, output_scale[23:16]};
      end
      ST_OU2: begin
        mac.init = 66'h8000;
        mac.a    = {12'd0, yq_mag};
        mac.b    = {1'b0, output_scale[15:0]};
      end
      ST_OU3: begin
        mac.load = 1'b0;
        mac.sh16 = 1'b1;
        mac.a    = {12'd0, yq_mag};
        mac.b    = {9'd0, output_scale[23:16]};
      end
      default: begin
        mac.en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      bandwidth    <= 17'd655;
      energy_floor <= 33'd4295;
      gain_ceiling <= 44'd16777216000000;
      output_scale <= 24'd65536;
      hold_gain    <= 1'b0;
      preset_gain  <= cagc_pkg::GAIN_ONE;
      gain         <= cagc_pkg::GAIN_ONE;
      energy       <= cagc_pkg::ENERGY_ONE;
      unclamped    <= 48'd0;
    end else begin
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            xi_mag <= in_i[15] ? 16'(-in_i) : in_i;
            xq_mag <= in_q[15] ? 16'(-in_q) : in_q;
            si     <= in_i[15];
            sq     <= in_q[15];
            state  <= ST_YI;
          end
        end
        ST_YI:  state <= ST_YQ;
        ST_YQ: begin
          yi_mag <= acc[59:24];
          state  <= ST_EI0;
        end
        ST_EI0: begin
          yq_mag <= acc[59:24];
          state  <= ST_EI1;
        end
        ST_EI1: state <= ST_EQ0;
        ST_EQ0: state <= ST_EQ1;
        ST_EQ1: state <= ST_SE0;
        ST_SE0: begin
          e_val <= (e4 > {4'd0, cagc_pkg::MAX48}) ? cagc_pkg::MAX48 : e4[47:0];
          state <= ST_SE1;
        end
        ST_SE1: state <= ST_SEW;
        ST_SEW: begin
          energy <= se_next;
          if (hold_gain) begin
            state <= ST_OUL;
          end else if (se_next > {15'd0, energy_floor}) begin
            nrm   <= se_next;
            p     <= 6'd47;
            step  <= 4'd0;
            state <= ST_NRM;
          end else begin
            gcalc <= {18'd0, gain};
            state <= ST_GW;
          end
        end
        ST_NRM: begin
          nrm <= nrm_next;
          if (nz) p <= p - sh_amt;
          if (step == 4'd5) begin
            m     <= nrm_next[47:16];
            frac  <= 16'd0;
            step  <= 4'd0;
            state <= ST_SQ0;
          end else begin
            step <= step + 4'd1;
          end
        end
        ST_SQ0: state <= ST_SQ1;
        ST_SQ1: state <= ST_SQN;
        ST_SQN: begin
          frac <= {frac[14:0], mq[32]};
          m    <= mq[32] ? mq[32:1] : mq[31:0];
          step <= step + 4'd1;
          state <= (step == 4'd15) ? ST_LG : ST_SQ0;
        end
        ST_LG: begin
          lneg  <= lval[22];
          state <= ST_EX;
        end
        ST_EX: begin
          f     <= ex[15:0];
          s     <= s_full[5:0];
          state <= ST_T1;
        end
        ST_T1: state <= ST_T2;
        ST_T2: state <= ST_T3;
        ST_T3: state <= ST_GR;
        ST_GR: begin
          gcalc <= 62'(acc >> s);
          state <= ST_GW;
        end
        ST_GW: begin
          unclamped <= ug_next;
          gain      <= (ug_next > {4'd0, gain_ceiling}) ? gain_ceiling : ug_next[43:0];
          state     <= ST_OU0;
        end
        ST_OU0: state <= ST_OU1;
        ST_OU1: state <= ST_OU2;
        ST_OU2: begin
          oi    <= cagc_pkg::sat16(si, acc[63:16]);
          state <= ST_OU3;
        end
        ST_OU3: state <= ST_OU4;
        ST_OU4: begin
          oq    <= cagc_pkg::sat16(sq, acc[63:16]);
          state <= ST_DONE;
        end
        ST_OUL: begin
          oi    <= cagc_pkg::sat16(si, {12'd0, yi_mag});
          oq    <= cagc_pkg::sat16(sq, {12'd0, yq_mag});
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            out_i             <= oi;
            out_q             <= oq;
            gain_now          <= gain;
            gain_before_clamp <= unclamped;
            out_valid         <= 1'b1;
            state             <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (cfg_wr) begin
        unique case (cfg_idx)
          cagc_pkg::REG_BANDWIDTH:    bandwidth    <= pwdata[16:0];
          cagc_pkg::REG_ENERGY_FLOOR: energy_floor <= pwdata[32:0];
          cagc_pkg::REG_GAIN_CEILING: gain_ceiling <= pwdata[43:0];
          cagc_pkg::REG_OUTPUT_SCALE: output_scale <= pwdata[23:0];
          cagc_pkg::REG_HOLD_GAIN:    hold_gain    <= pwdata[0];
          cagc_pkg::REG_PRESET_GAIN: begin
            preset_gain <= pwdata[43:0];
            gain        <= pwdata[43:0];
            energy      <= cagc_pkg::ENERGY_ONE;
          end
          default: ;
        endcase
      end
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while idle did not start work");

  a_clamp_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_GW && !cfg_wr) |=> ({4'd0, gain} <= unclamped))
    else $error("clamped gain above unclamped gain");

  a_square_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SQN) |-> (acc[65:64] == 2'b00))
    else $error("log2 mantissa square out of range");

endmodule
`default_nettype wire

>>> rtl/core/cagc_mac.sv
`default_nettype none
module cagc_mac (
  input  wire logic              clk,
  input  wire cagc_pkg::mac_ctl_t ctl,
  output logic [65:0]            acc
);

  logic [64:0] prod;
  logic [65:0] prod_ext;

  assign prod     = ctl.a * ctl.b;
  assign prod_ext = ctl.sh16 ? {prod[49:0], 16'h0000} : {1'b0, prod};

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc <= (ctl.load ? ctl.init : acc) + prod_ext;
    end
  end

endmodule
`default_nettype wire
